// ===== src/esc_throttle_safety_limiter_top_defines.svh =====
// assertion macros for the throttle safety limiter
`ifndef ESC_THROTTLE_SAFETY_LIMITER_TOP_DEFINES_SVH
`define ESC_THROTTLE_SAFETY_LIMITER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ETSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("etsl same-cycle check failed");

// next-cycle implication, checked out of reset
`define ETSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("etsl next-cycle check failed");

`endif

// ===== src/etsl_pkg.sv =====
// shared types and constants for the throttle safety limiter
`default_nettype none

package etsl_pkg;

    // led command codes
    typedef enum logic [1:0] {
        LED_NONE  = 2'd0,
        LED_RED   = 2'd1,
        LED_GREEN = 2'd2
    } t_led;

    // configuration register indexes
    localparam logic [2:0] CFG_BATTERY_MIN_MV   = 3'd0;
    localparam logic [2:0] CFG_ESC_MAX_TEMP     = 3'd1;
    localparam logic [2:0] CFG_MOTOR_MAX_TEMP   = 3'd2;
    localparam logic [2:0] CFG_CURRENT_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_RECOVERY_PERCENT = 3'd4;
    localparam logic [2:0] CFG_PULSE_MIN_US     = 3'd5;
    localparam logic [2:0] CFG_PULSE_MAX_US     = 3'd6;
    localparam logic [2:0] CFG_LIMIT_ENABLE     = 3'd7;

    // limiter constants
    localparam logic [6:0]  LOW_THROTTLE_CUTOFF = 7'd5;
    localparam logic [31:0] CLAMP_AFTER_MS      = 32'd10000;
    localparam logic [31:0] REDUCE_AFTER_MS     = 32'd3000;
    localparam logic [6:0]  REDUCE_STEP         = 7'd10;

    // divide by 100 for values below 2^19: (x * RECIP_100) >> RECIP_SHIFT
    localparam int          RECIP_SHIFT = 26;
    localparam logic [19:0] RECIP_100   = 20'd671089;

    // pulse ceiling
    localparam logic [11:0] PULSE_MAX = 12'd4095;

endpackage

`default_nettype wire

// ===== src/esc_throttle_safety_limiter_top.sv =====
// throttle safety limiter: three-stage pipeline from telemetry request to pulse result
//
// One request per control tick enters on i_valid / o_stall with telemetry, throttle
// state and time; one result leaves on o_valid / i_stall with the enable flag,
// pulse width, led command, ramp-down and cruise-cancel requests.
// The request passes the input register, the decision stage (limiting, output-enable
// and overcurrent state, percent times span) and the scaling stage (divide by 100
// through a reciprocal multiply, offset, saturate) into the result register.
// Throughput is one request per cycle while i_stall is low; the enable flag and
// overcurrent timer are updated as a request leaves the input register, so the
// next request sees them. When the receiver holds i_stall each stage keeps its
// request and o_stall rises once the input register is full and cannot move;
// bubbles are squeezed out. Configuration writes use i_cfg_valid / o_cfg_ready
// (always ready) and must be made while no request is in flight.
// Synchronous active-low reset empties the pipeline, detaches the output, clears
// the overcurrent timer and loads the register defaults.
`default_nettype none

module esc_throttle_safety_limiter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_link_ready,
    input  wire logic [15:0] i_battery_mv,
    input  wire logic [7:0]  i_esc_temp,
    input  wire logic [7:0]  i_motor_temp,
    input  wire logic [15:0] i_current_reading,
    input  wire logic [6:0]  i_throttle_percent,
    input  wire logic        i_armed,
    input  wire logic        i_ramp_active,
    input  wire logic [6:0]  i_ramp_percent,
    input  wire logic        i_cruise_active,
    input  wire logic [6:0]  i_cruise_percent,
    input  wire logic [31:0] i_now_ms,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_output_enabled,
    output logic             o_pulse_valid,
    output logic [11:0]      o_pulse_us,
    output logic [1:0]       o_led_command,
    output logic             o_ramp_to_zero,
    output logic             o_cancel_cruise
);

    `include "esc_throttle_safety_limiter_top_defines.svh"

    // configuration registers
    logic [15:0] r_battery_min_mv;
    logic [7:0]  r_esc_max_temp;
    logic [7:0]  r_motor_max_temp;
    logic [15:0] r_current_limit;
    logic [6:0]  r_recovery_percent;
    logic [11:0] r_pulse_min_us;
    logic [11:0] r_pulse_max_us;
    logic        r_limit_enable;

    // block state
    logic        r_attached;
    logic        n_attached;
    logic        r_oc_seen;
    logic        n_oc_seen;
    logic [31:0] r_oc_start;
    logic [31:0] n_oc_start;

    // input register
    logic        r_in_v;
    logic        r_in_link;
    logic [15:0] r_in_batt;
    logic [7:0]  r_in_etemp;
    logic [7:0]  r_in_mtemp;
    logic [15:0] r_in_cur;
    logic [6:0]  r_in_thr;
    logic        r_in_armed;
    logic        r_in_ramp_on;
    logic [6:0]  r_in_ramp_p;
    logic        r_in_cruise_on;
    logic [6:0]  r_in_cruise_p;
    logic [31:0] r_in_now;

    // decision stage register
    logic        r_s1_v;
    logic        r_s1_att;
    logic        r_s1_pvalid;
    etsl_pkg::t_led r_s1_led;
    logic        r_s1_rz;
    logic        r_s1_cancel;
    logic [18:0] r_s1_mag;
    logic        r_s1_neg;

    // result register
    logic        r_o_v;
    logic        r_o_att;
    logic        r_o_pvalid;
    logic [11:0] r_o_pulse;
    etsl_pkg::t_led r_o_led;
    logic        r_o_rz;
    logic        r_o_cancel;

    // pipeline flow
    logic        out_load;
    logic        s1_load;
    logic        in_move;
    logic        in_accept;

    // decision stage logic
    logic        low_batt;
    logic        temp_hot;
    logic        over_cur;
    logic [31:0] elapsed;
    logic        pvalid;
    etsl_pkg::t_led led;
    logic        rz;
    logic        cancel;
    logic [6:0]  pct;
    logic [6:0]  thr_clamp;
    logic [6:0]  thr_reduced;
    logic signed [12:0] span;
    logic [11:0] span_mag;
    logic [18:0] mag;

    // scaling stage logic
    logic [38:0] quot_full;
    logic [12:0] quot;
    logic signed [14:0] pulse_s;
    logic [11:0] pulse_sat;

    // flow control: every stage moves when the one after it is free or moving
    assign out_load  = !r_o_v || !i_stall;
    assign s1_load   = !r_s1_v || out_load;
    assign in_move   = r_in_v && s1_load;
    assign o_stall   = r_in_v && !s1_load;
    assign in_accept = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_battery_min_mv   <= 16'd42000;
            r_esc_max_temp     <= 8'd110;
            r_motor_max_temp   <= 8'd120;
            r_current_limit    <= 16'd1400;
            r_recovery_percent <= 7'd30;
            r_pulse_min_us     <= 12'd1000;
            r_pulse_max_us     <= 12'd2000;
            r_limit_enable     <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                etsl_pkg::CFG_BATTERY_MIN_MV:   r_battery_min_mv   <= i_cfg_data;
                etsl_pkg::CFG_ESC_MAX_TEMP:     r_esc_max_temp     <= i_cfg_data[7:0];
                etsl_pkg::CFG_MOTOR_MAX_TEMP:   r_motor_max_temp   <= i_cfg_data[7:0];
                etsl_pkg::CFG_CURRENT_LIMIT:    r_current_limit    <= i_cfg_data;
                etsl_pkg::CFG_RECOVERY_PERCENT: r_recovery_percent <= i_cfg_data[6:0];
                etsl_pkg::CFG_PULSE_MIN_US:     r_pulse_min_us     <= i_cfg_data[11:0];
                etsl_pkg::CFG_PULSE_MAX_US:     r_pulse_max_us     <= i_cfg_data[11:0];
                etsl_pkg::CFG_LIMIT_ENABLE:     r_limit_enable     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_accept) begin
            r_in_v <= 1'b1;
        end else if (in_move) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_link      <= i_link_ready;
            r_in_batt      <= i_battery_mv;
            r_in_etemp     <= i_esc_temp;
            r_in_mtemp     <= i_motor_temp;
            r_in_cur       <= i_current_reading;
            r_in_thr       <= i_throttle_percent;
            r_in_armed     <= i_armed;
            r_in_ramp_on   <= i_ramp_active;
            r_in_ramp_p    <= i_ramp_percent;
            r_in_cruise_on <= i_cruise_active;
            r_in_cruise_p  <= i_cruise_percent;
            r_in_now       <= i_now_ms;
        end
    end

    // limiter conditions
    assign low_batt = r_in_link && (r_in_batt <= r_battery_min_mv);
    assign temp_hot = (r_in_link && (r_in_etemp >= r_esc_max_temp))
                      || (r_in_mtemp >= r_motor_max_temp);
    assign over_cur = r_in_link && (r_in_cur >= r_current_limit);
    assign elapsed  = r_in_now - r_oc_start;
    assign thr_clamp   = (r_in_thr < r_recovery_percent) ? r_in_thr : r_recovery_percent;
    assign thr_reduced = (r_in_thr > etsl_pkg::REDUCE_STEP)
                         ? (r_in_thr - etsl_pkg::REDUCE_STEP) : 7'd0;

    // enable flag, led, throttle choice and overcurrent timer
    always_comb begin
        n_attached = r_attached;
        n_oc_seen  = r_oc_seen;
        n_oc_start = r_oc_start;
        pvalid     = 1'b0;
        led        = etsl_pkg::LED_NONE;
        rz         = 1'b0;
        cancel     = 1'b0;
        pct        = r_in_thr;
        if (low_batt && r_attached && !r_in_ramp_on
                && (r_in_thr < etsl_pkg::LOW_THROTTLE_CUTOFF)) begin
            // throttle already near zero: detach quietly
            n_attached = 1'b0;
        end else if (low_batt && !r_attached) begin
            // detached on low battery: nothing written
            n_attached = 1'b0;
        end else begin
            if (low_batt && !r_in_ramp_on) begin
                led = etsl_pkg::LED_RED;
                rz  = 1'b1;
            end
            if (!r_in_armed) begin
                if (r_attached) begin
                    n_attached = 1'b0;
                    led        = etsl_pkg::LED_RED;
                end
            end else begin
                if (!r_attached) begin
                    n_attached = 1'b1;
                    led        = etsl_pkg::LED_GREEN;
                end
                pvalid = 1'b1;
                if (r_in_ramp_on) begin
                    pct = r_in_ramp_p;
                end else if (r_in_cruise_on) begin
                    pct = r_in_cruise_p;
                end
                if (r_limit_enable) begin
                    if (temp_hot) begin
                        cancel = 1'b1;
                        pct    = thr_clamp;
                    end else if (over_cur) begin
                        cancel = 1'b1;
                        if (!r_oc_seen) begin
                            n_oc_seen  = 1'b1;
                            n_oc_start = r_in_now;
                            pct        = r_in_thr;
                        end else if (elapsed > etsl_pkg::CLAMP_AFTER_MS) begin
                            pct = thr_clamp;
                        end else if (elapsed > etsl_pkg::REDUCE_AFTER_MS) begin
                            pct = thr_reduced;
                        end else begin
                            pct = r_in_thr;
                        end
                    end else begin
                        n_oc_seen = 1'b0;
                    end
                end
            end
        end
    end

    // percent times pulse span, kept as magnitude and sign
    assign span     = $signed({1'b0, r_pulse_max_us}) - $signed({1'b0, r_pulse_min_us});
    assign span_mag = span[12] ? 12'(-span) : span[11:0];
    assign mag      = 19'(pct) * 19'(span_mag);

    // state update as a request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached <= 1'b0;
            r_oc_seen  <= 1'b0;
        end else if (in_move) begin
            r_attached <= n_attached;
            r_oc_seen  <= n_oc_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_oc_start <= n_oc_start;
        end
    end

    // decision stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_load) begin
            r_s1_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_s1_att    <= n_attached;
            r_s1_pvalid <= pvalid;
            r_s1_led    <= led;
            r_s1_rz     <= rz;
            r_s1_cancel <= cancel;
            r_s1_mag    <= mag;
            r_s1_neg    <= span[12];
        end
    end

    // divide by 100 toward zero, add offset, saturate to the pulse range
    assign quot_full = 39'(r_s1_mag) * 39'(etsl_pkg::RECIP_100);
    assign quot      = quot_full[etsl_pkg::RECIP_SHIFT +: 13];
    assign pulse_s   = (r_s1_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot}))
                       + $signed({3'b000, r_pulse_min_us});

    always_comb begin
        if (pulse_s < 0) begin
            pulse_sat = 12'd0;
        end else if (pulse_s > $signed({3'b000, etsl_pkg::PULSE_MAX})) begin
            pulse_sat = etsl_pkg::PULSE_MAX;
        end else begin
            pulse_sat = pulse_s[11:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_load) begin
            r_o_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_v) begin
            r_o_att    <= r_s1_att;
            r_o_pvalid <= r_s1_pvalid;
            r_o_pulse  <= r_s1_pvalid ? pulse_sat : 12'd0;
            r_o_led    <= r_s1_led;
            r_o_rz     <= r_s1_rz;
            r_o_cancel <= r_s1_cancel;
        end
    end

    assign o_valid          = r_o_v;
    assign o_output_enabled = r_o_att;
    assign o_pulse_valid    = r_o_pvalid;
    assign o_pulse_us       = r_o_pulse;
    assign o_led_command    = r_o_led;
    assign o_ramp_to_zero   = r_o_rz;
    assign o_cancel_cruise  = r_o_cancel;

    // result consistency checks
    `ETSL_ASSERT_NOW(a_pulse_needs_enable, o_valid && o_pulse_valid, o_output_enabled)
    `ETSL_ASSERT_NOW(a_no_pulse_is_zero, o_valid && !o_pulse_valid, o_pulse_us == 12'd0)
    `ETSL_ASSERT_NOW(a_green_means_pulse, o_valid && (o_led_command == etsl_pkg::LED_GREEN), o_pulse_valid && o_output_enabled)
    `ETSL_ASSERT_NOW(a_ramp_zero_is_red, o_valid && o_ramp_to_zero, o_led_command == etsl_pkg::LED_RED)
    `ETSL_ASSERT_NOW(a_cancel_needs_pulse, o_valid && o_cancel_cruise, o_pulse_valid)
    `ETSL_ASSERT_NEXT(a_state_holds_when_stuck, !in_move, $stable(r_attached) && $stable(r_oc_seen))

endmodule

`default_nettype wire
